### design/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg
// shared types and constants of the sbus frame decoder
// ----------------------------------------------------------------------------
package sbfd_pkg;

    // framing
    localparam int FRAME_LEN  = 25;
    localparam int FRAME_BITS = FRAME_LEN * 8;
    localparam int IDX_W      = 5;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE    = 8'h00;
    localparam int FLAG_FS_BIT   = 3;
    localparam int FLAG_LOST_BIT = 2;

    // channels
    localparam int RAW_W  = 11;
    localparam int NUM_CH = 16;
    localparam int CH_W   = 4;
    localparam int VAL_W  = 11;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

    // scaling: 172..1811 onto 1000..2000, reciprocal multiply exact over the raw range
    localparam int IN_LO  = 172;
    localparam int IN_HI  = 1811;
    localparam int OUT_LO = 1000;
    localparam int OUT_HI = 2000;
    localparam int SCALE_SHIFT = 22;
    localparam int MUL_W       = 22;
    localparam int PROD_W      = RAW_W + MUL_W;
    localparam longint SCALE_MUL =
        ((OUT_HI - OUT_LO) * (64'd1 << SCALE_SHIFT) + (IN_HI - IN_LO) - 1) / (IN_HI - IN_LO);

    // timers
    localparam int GAP_W  = 8;
    localparam int LOSS_W = 10;
    localparam int CFG_DATA_W = 10;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } t_req;

    typedef enum logic {
        RES_CHANNEL = 1'b0,
        RES_LOST    = 1'b1
    } t_res;

    typedef enum logic {
        CFG_GAP  = 1'b0,
        CFG_LOSS = 1'b1
    } t_cfg_idx;

endpackage

### design/sbfd_scale.sv
// ----------------------------------------------------------------------------
// sbfd_scale
// shared channel scaling unit: one multiply stage, then offset and clamp
// ----------------------------------------------------------------------------
module sbfd_scale (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [sbfd_pkg::RAW_W-1:0]  i_raw,
    output logic [sbfd_pkg::VAL_W-1:0]  o_value
);
    import sbfd_pkg::*;

    logic [RAW_W-1:0]  diff;
    logic [PROD_W-1:0] r_prod;
    logic              r_below;
    logic [VAL_W-1:0]  quot;
    logic [VAL_W:0]    sum;

    assign diff = i_raw - RAW_W'(IN_LO);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod  <= PROD_W'(diff) * PROD_W'(SCALE_MUL);
            r_below <= (i_raw < RAW_W'(IN_LO));
        end
    end

    // raw below the input floor always lands on the output floor
    assign quot = r_prod[PROD_W-1:SCALE_SHIFT];
    assign sum  = {1'b0, quot} + (VAL_W+1)'(OUT_LO);

    always_comb begin
        if (r_below) begin
            o_value = VAL_W'(OUT_LO);
        end else if (sum > (VAL_W+1)'(OUT_HI)) begin
            o_value = VAL_W'(OUT_HI);
        end else begin
            o_value = sum[VAL_W-1:0];
        end
    end

endmodule

### design/sbus_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_top
// sbus receiver: frames serial bytes, decodes sixteen scaled channels
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests: tuser = kind (0 serial byte, 1 millisecond tick),
//   tdata = received byte.
//   m_axis carries results: channel values after a good frame (16 results,
//   tlast on channel 15) or one signal-lost result when the loss timer expires.
//   cfg channel writes gap timeout (index 0) and loss timeout (index 1); it is
//   always ready; the user must write it only while the block is idle, the block does not check.
// sequencing
//   the byte that completes a good frame starts the decode sequencer: each
//   channel passes the one shared scaling multiplier (ST_MUL, then ST_EMIT),
//   and the sequencer waits on any output stall. a tick that raises a
//   signal-lost result passes through ST_LOST before the block is idle again.
//   s_axis_tready is low while the sequencer runs or a signal-lost result waits.
// reset
//   i_rst_n (synchronous, active low) clears framing, timers and flags and
//   loads the timeouts with 3 ms and 100 ms.
// stall
//   the output register holds a result until m_axis_tready; the sequencer
//   waits on it, so nothing is dropped.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sbfd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                        s_axis_tuser,   // [0] req_type
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sbfd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [3:0] channel,
                                                              // [14:4] value,
                                                              // [15] failsafe,
                                                              // [16] frame_lost,
                                                              // [23:17] zero
    output logic [0:0]                        m_axis_tuser,   // [0] result_kind
    output logic                              m_axis_tlast,   // last
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [0:0]                        i_cfg_index,
    input  logic [sbfd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sbfd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT,
        ST_LOST
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_byte_idx, n_byte_idx;
    logic [GAP_W-1:0]   r_gap_cnt, n_gap_cnt;
    logic [LOSS_W-1:0]  r_loss_cnt, n_loss_cnt;
    logic               r_failsafe, n_failsafe;
    logic               r_lost_frame, n_lost_frame;
    logic               r_lost_rep, n_lost_rep;
    logic [GAP_W-1:0]   r_gap_to, n_gap_to;
    logic [LOSS_W-1:0]  r_loss_to, n_loss_to;
    logic [CH_W-1:0]    r_ch, n_ch;

    logic               r_out_valid, n_out_valid;
    t_res               r_out_kind, n_out_kind;
    logic [CH_W-1:0]    r_out_ch, n_out_ch;
    logic [VAL_W-1:0]   r_out_val, n_out_val;
    logic               r_out_fs, n_out_fs;
    logic               r_out_fl, n_out_fl;
    logic               r_out_last, n_out_last;

    logic [FRAME_BITS-1:0] r_frame;

    logic               in_acc;
    logic               cfg_acc;
    logic               slot_free;
    logic               byte_store;
    logic               emit;
    logic               scale_load;
    logic [VAL_W-1:0]   scaled;
    logic [7:0]         rx_byte;
    t_req               req;

    assign rx_byte       = s_axis_tdata;
    assign req           = t_req'(s_axis_tuser[0]);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign slot_free     = !r_out_valid || m_axis_tready;

    // a byte before the header is dropped
    assign byte_store = (r_byte_idx != '0) || (rx_byte == HEADER_BYTE);
    assign emit       = (r_state == ST_EMIT) && slot_free;
    assign scale_load = (r_state == ST_MUL);

    // channel bits start at bit 8 of the frame; shifted down 11 per channel
    sbfd_scale u_scale (
        .i_clk   (i_clk),
        .i_load  (scale_load),
        .i_raw   (r_frame[8 +: RAW_W]),
        .o_value (scaled)
    );

    always_comb begin
        n_state      = r_state;
        n_byte_idx   = r_byte_idx;
        n_gap_cnt    = r_gap_cnt;
        n_loss_cnt   = r_loss_cnt;
        n_failsafe   = r_failsafe;
        n_lost_frame = r_lost_frame;
        n_lost_rep   = r_lost_rep;
        n_gap_to     = r_gap_to;
        n_loss_to    = r_loss_to;
        n_ch         = r_ch;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_ch     = r_out_ch;
        n_out_val    = r_out_val;
        n_out_fs     = r_out_fs;
        n_out_fl     = r_out_fl;
        n_out_last   = r_out_last;

        if (cfg_acc) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAP:  n_gap_to  = i_cfg_data[GAP_W-1:0];
                CFG_LOSS: n_loss_to = i_cfg_data[LOSS_W-1:0];
                default:  ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && req == REQ_BYTE) begin
                    n_gap_cnt = '0;
                    if (byte_store) begin
                        if (r_byte_idx == LAST_IDX) begin
                            n_byte_idx = '0;
                            // end byte check; flags sit in the top byte before the shift
                            if (rx_byte == END_BYTE) begin
                                n_failsafe   = r_frame[FRAME_BITS-8+FLAG_FS_BIT];
                                n_lost_frame = r_frame[FRAME_BITS-8+FLAG_LOST_BIT];
                                n_loss_cnt   = '0;
                                n_lost_rep   = 1'b0;
                                n_ch         = '0;
                                n_state      = ST_MUL;
                            end
                        end else begin
                            n_byte_idx = r_byte_idx + 1'b1;
                        end
                    end
                end else if (in_acc) begin
                    if (r_gap_cnt != '1) begin
                        n_gap_cnt = r_gap_cnt + 1'b1;
                    end
                    if (n_gap_cnt > r_gap_to && r_byte_idx != '0) begin
                        n_byte_idx = '0;
                    end
                    if (r_loss_cnt != '1) begin
                        n_loss_cnt = r_loss_cnt + 1'b1;
                    end
                    if (n_loss_cnt > r_loss_to) begin
                        n_failsafe = 1'b1;
                        if (!r_lost_rep) begin
                            n_lost_rep = 1'b1;
                            n_state    = ST_LOST;
                        end
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = RES_CHANNEL;
                    n_out_ch    = r_ch;
                    n_out_val   = scaled;
                    n_out_fs    = r_failsafe;
                    n_out_fl    = r_lost_frame;
                    n_out_last  = (r_ch == LAST_CH);
                    if (r_ch == LAST_CH) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_LOST: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = RES_LOST;
                    n_out_ch    = '0;
                    n_out_val   = '0;
                    n_out_fs    = r_failsafe;
                    n_out_fl    = r_lost_frame;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_byte_idx   <= '0;
            r_gap_cnt    <= '0;
            r_loss_cnt   <= '0;
            r_failsafe   <= 1'b0;
            r_lost_frame <= 1'b0;
            r_lost_rep   <= 1'b0;
            r_gap_to     <= GAP_W'(3);
            r_loss_to    <= LOSS_W'(100);
            r_ch         <= '0;
            r_out_valid  <= 1'b0;
            r_out_kind   <= RES_CHANNEL;
            r_out_ch     <= '0;
            r_out_val    <= '0;
            r_out_fs     <= 1'b0;
            r_out_fl     <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_byte_idx   <= n_byte_idx;
            r_gap_cnt    <= n_gap_cnt;
            r_loss_cnt   <= n_loss_cnt;
            r_failsafe   <= n_failsafe;
            r_lost_frame <= n_lost_frame;
            r_lost_rep   <= n_lost_rep;
            r_gap_to     <= n_gap_to;
            r_loss_to    <= n_loss_to;
            r_ch         <= n_ch;
            r_out_valid  <= n_out_valid;
            r_out_kind   <= n_out_kind;
            r_out_ch     <= n_out_ch;
            r_out_val    <= n_out_val;
            r_out_fs     <= n_out_fs;
            r_out_fl     <= n_out_fl;
            r_out_last   <= n_out_last;
        end
    end

    // frame shift line: bytes enter at the top, byte 0 ends at the bottom
    always_ff @(posedge i_clk) begin
        if (in_acc && req == REQ_BYTE && byte_store) begin
            r_frame <= {rx_byte, r_frame[FRAME_BITS-1:8]};
        end else if (emit) begin
            r_frame <= r_frame >> RAW_W;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {(OUT_TDATA_W-CH_W-VAL_W-2)'(0), r_out_fl, r_out_fs,
                            r_out_val, r_out_ch};

`ifndef SYNTHESIS
    // a tick never disturbs the stored frame
    a_tick_keeps_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && req == REQ_TICK) |=> $stable(r_frame))
        else $error("frame changed on a tick request");

    // framing index stays inside the frame
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= LAST_IDX)
        else $error("byte index beyond frame length");

    // a signal-lost result always carries failsafe
    a_lost_failsafe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == RES_LOST) |-> r_out_fs)
        else $error("signal-lost result without failsafe");

    // channel results end the frame exactly on the last channel
    a_last_on_ch15: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == RES_CHANNEL) |-> (r_out_last == (r_out_ch == LAST_CH)))
        else $error("tlast not aligned with final channel");

    // a pending result is not overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_ch)))
        else $error("stalled result lost or replaced");
`endif

endmodule
